// ===== src/sha1e_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 engine.
// No dependencies; imported by every module of the engine.
`timescale 1ns / 1ps
`default_nettype none

package sha1e_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 5;
    localparam int TOTAL_W     = 61;
    localparam int ROUND_W     = 7;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [7:0]         PAD_BYTE   = 8'h80;

    // Initial chain value, element 0 is H0.
    localparam logic [CHAIN_WORDS-1:0][WORD_W-1:0] INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WORD_W-1:0] K_CH  = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_P1  = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_P2  = 32'hCA62C1D6;

    // One 512-bit block handed from the front end to the compression core.
    typedef struct packed {
        logic                               is_final;
        logic [BLOCK_WORDS-1:0][WORD_W-1:0] words;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PAD,
        F_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROUND,
        B_FINISH
    } back_state_t;

    function automatic logic [WORD_W-1:0] round_f(
        input logic [ROUND_W-1:0] rnd,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        if (rnd < 7'd20)
            f = (b & c) | (~b & d);
        else if (rnd < 7'd40)
            f = b ^ c ^ d;
        else if (rnd < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        if (rnd < 7'd20)
            k = K_CH;
        else if (rnd < 7'd40)
            k = K_P1;
        else if (rnd < 7'd60)
            k = K_MAJ;
        else
            k = K_P2;
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== src/sha1_hash_engine_core.sv =====
// Top level of the streaming SHA-1 engine.
// Depends on sha1e_pkg, sha1e_front, sha1e_blkq and sha1e_back.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+------------------------------------
//   input   | in        | push / full         | data_byte, has_byte, last
//   result  | out       | empty / pop         | digest_word0 .. digest_word4
//
// Flow: the front end takes one input word per cycle while full is low. Each 64-byte
// block then passes through the compression core (load, 80 rounds, chain add), so the
// core sets the sustained rate. A last word adds the padding states, F_PAD and then
// F_LEN if the length does not fit, and one or two compressions before the digest.
// Reset: chain value to the initial constants, queues empty; no clearing pass.
// Stalls: full rises while the front end pads or its finished block waits on
// a full two-block queue; a digest that is not popped holds the core at the
// end of the final block, while the front end keeps taking bytes.
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_engine_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  data_byte,
    input  wire         has_byte,
    input  wire         last,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] digest_word0,
    output logic [31:0] digest_word1,
    output logic [31:0] digest_word2,
    output logic [31:0] digest_word3,
    output logic [31:0] digest_word4
);
    import sha1e_pkg::*;

    // front end to block queue
    logic  fq_push;
    job_t  fq_job;
    logic  fq_full;
    // block queue to core
    logic  qb_pop;
    job_t  qb_job;
    logic  qb_empty;

    logic [CHAIN_WORDS-1:0][WORD_W-1:0] digest;

    sha1e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last      (last),
        .q_push    (fq_push),
        .q_job     (fq_job),
        .q_full    (fq_full)
    );

    sha1e_blkq u_blkq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_job  (fq_job),
        .q_full  (fq_full),
        .rd_en   (qb_pop),
        .rd_job  (qb_job),
        .q_empty (qb_empty)
    );

    sha1e_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_pop   (qb_pop),
        .q_job   (qb_job),
        .q_empty (qb_empty),
        .empty   (empty),
        .pop     (pop),
        .digest  (digest)
    );

    // H0 goes out first, each word most significant byte first
    assign digest_word0 = digest[0];
    assign digest_word1 = digest[1];
    assign digest_word2 = digest[2];
    assign digest_word3 = digest[3];
    assign digest_word4 = digest[4];

endmodule

`default_nettype wire

// ===== src/sha1e_front.sv =====
// Front end: packs message bytes into blocks, appends padding and length.
// Depends on sha1e_pkg; feeds sha1e_blkq.
`timescale 1ns / 1ps
`default_nettype none

module sha1e_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire  [7:0]           data_byte,
    input  wire                  has_byte,
    input  wire                  last,
    output logic                 q_push,
    output sha1e_pkg::job_t      q_job,
    input  wire                  q_full
);
    import sha1e_pkg::*;

    front_state_t         state_reg, state_next;
    job_t                 job_reg, job_next;
    logic                 rdy_reg, rdy_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    logic [5:0]           pos;
    logic [3:0]           widx;
    logic [1:0]           lane;
    logic [63:0]          bit_len;
    logic                 slot_free;
    logic                 accept;

    // Store a byte at a lane of a word; lanes below it are cleared.
    function automatic logic [WORD_W-1:0] put_byte(
        input logic [WORD_W-1:0] w,
        input logic [1:0]        ln,
        input logic [7:0]        b
    );
        logic [WORD_W-1:0] r;
        case (ln)
            2'd0:    r = {b, 24'h000000};
            2'd1:    r = {w[31:24], b, 16'h0000};
            2'd2:    r = {w[31:16], b, 8'h00};
            default: r = {w[31:8], b};
        endcase
        return r;
    endfunction

    assign pos       = total_reg[5:0];
    assign widx      = pos[5:2];
    assign lane      = pos[1:0];
    assign bit_len   = {total_reg, 3'b000};
    assign slot_free = !rdy_reg || !q_full;
    assign full      = (state_reg != F_IDLE) || !slot_free;
    assign accept    = push && !full;
    assign q_push    = rdy_reg && !q_full;
    assign q_job     = job_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && last)
                    state_next = F_PAD;
            end
            F_PAD:
            begin
                if (slot_free)
                    state_next = (pos >= 6'd56) ? F_LEN : F_IDLE;
            end
            F_LEN:
            begin
                if (slot_free)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        job_next   = job_reg;
        rdy_next   = rdy_reg && q_full;
        total_next = total_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && has_byte)
                begin
                    job_next.words[widx] = put_byte(job_reg.words[widx], lane, data_byte);
                    job_next.is_final    = 1'b0;
                    total_next           = total_reg + 1'b1;
                    if (pos == 6'd63)
                        rdy_next = 1'b1;
                end
            end
            F_PAD:
            begin
                if (slot_free)
                begin
                    for (int i = 0; i < BLOCK_WORDS; i++)
                    begin
                        if (4'(i) > widx)
                            job_next.words[i] = '0;
                    end
                    job_next.words[widx] = put_byte(job_reg.words[widx], lane, PAD_BYTE);
                    if (pos < 6'd56)
                    begin
                        job_next.words[14] = bit_len[63:32];
                        job_next.words[15] = bit_len[31:0];
                        job_next.is_final  = 1'b1;
                        total_next         = '0;
                    end
                    else
                    begin
                        job_next.is_final = 1'b0;
                    end
                    rdy_next = 1'b1;
                end
            end
            F_LEN:
            begin
                if (slot_free)
                begin
                    for (int i = 0; i < BLOCK_WORDS - 2; i++)
                        job_next.words[i] = '0;
                    job_next.words[14] = bit_len[63:32];
                    job_next.words[15] = bit_len[31:0];
                    job_next.is_final  = 1'b1;
                    total_next         = '0;
                    rdy_next           = 1'b1;
                end
            end
            default: rdy_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rdy_reg   <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rdy_reg   <= rdy_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

// ===== src/sha1e_blkq.sv =====
// Two-entry block queue between the front end and the compression core.
// Depends on sha1e_pkg for the block type.
`timescale 1ns / 1ps
`default_nettype none

module sha1e_blkq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  sha1e_pkg::job_t      wr_job,
    output logic                 q_full,
    input  wire                  rd_en,
    output sha1e_pkg::job_t      rd_job,
    output logic                 q_empty
);
    import sha1e_pkg::*;

    job_t        mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

// ===== src/sha1e_back.sv =====
// Compression core: 80 rounds per block, chain update and digest register.
// Depends on sha1e_pkg; takes blocks from sha1e_blkq.
`timescale 1ns / 1ps
`default_nettype none

module sha1e_back (
    input  wire                                    clk,
    input  wire                                    rst_n,
    output logic                                   q_pop,
    input  sha1e_pkg::job_t                        q_job,
    input  wire                                    q_empty,
    output logic                                   empty,
    input  wire                                    pop,
    output logic [sha1e_pkg::CHAIN_WORDS-1:0][31:0] digest
);
    import sha1e_pkg::*;

    back_state_t                        state_reg, state_next;
    logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_reg, chain_next;
    logic [CHAIN_WORDS-1:0][WORD_W-1:0] wv_reg, wv_next;
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] win_reg, win_next;
    logic [CHAIN_WORDS-1:0][WORD_W-1:0] digest_reg, digest_next;
    logic [CHAIN_WORDS-1:0][WORD_W-1:0] sum;
    logic [ROUND_W-1:0]                 round_reg, round_next;
    logic                               final_reg, final_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_free;
    logic [WORD_W-1:0]                  t_word;
    logic [WORD_W-1:0]                  w_new;

    assign empty    = !out_valid_reg;
    assign digest   = digest_reg;
    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        for (int i = 0; i < CHAIN_WORDS; i++)
            sum[i] = chain_reg[i] + wv_reg[i];
    end

    // Round datapath: a is wv[0] ... e is wv[4]; win[0] is the current schedule word.
    assign t_word = {wv_reg[0][26:0], wv_reg[0][31:27]}
                  + round_f(round_reg, wv_reg[1], wv_reg[2], wv_reg[3])
                  + wv_reg[4] + round_k(round_reg) + win_reg[0];
    assign w_new  = {win_reg[13][30:0] ^ win_reg[8][30:0] ^ win_reg[2][30:0] ^ win_reg[0][30:0],
                     win_reg[13][31] ^ win_reg[8][31] ^ win_reg[2][31] ^ win_reg[0][31]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                    state_next = B_ROUND;
            end
            B_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = B_FINISH;
            end
            B_FINISH:
            begin
                if (!final_reg || out_free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        chain_next     = chain_reg;
        wv_next        = wv_reg;
        win_next       = win_reg;
        digest_next    = digest_reg;
        round_next     = round_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    win_next   = q_job.words;
                    final_next = q_job.is_final;
                    wv_next    = chain_reg;
                    round_next = '0;
                end
            end
            B_ROUND:
            begin
                wv_next[4] = wv_reg[3];
                wv_next[3] = wv_reg[2];
                wv_next[2] = {wv_reg[1][1:0], wv_reg[1][31:2]};
                wv_next[1] = wv_reg[0];
                wv_next[0] = t_word;
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    win_next[i] = win_reg[i+1];
                win_next[BLOCK_WORDS-1] = w_new;
                round_next = (round_reg == LAST_ROUND) ? '0 : round_reg + 7'd1;
            end
            B_FINISH:
            begin
                if (!final_reg)
                begin
                    chain_next = sum;
                end
                else if (out_free)
                begin
                    digest_next    = sum;
                    out_valid_next = 1'b1;
                    chain_next     = INIT_CHAIN;
                end
            end
            default: round_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            chain_reg     <= INIT_CHAIN;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            round_reg     <= round_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg     <= wv_next;
        win_reg    <= win_next;
        digest_reg <= digest_next;
    end

endmodule

`default_nettype wire

// ===== src/sha1e_checker.sv =====
// Port-level checks for sha1_hash_engine_core, attached with a bind.
// No package dependency; sees the top-level ports only.
`timescale 1ns / 1ps
`default_nettype none

module sha1e_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        push,
    input wire        full,
    input wire        last,
    input wire        pop,
    input wire        empty,
    input wire [31:0] digest_word0,
    input wire [31:0] digest_word1,
    input wire [31:0] digest_word2,
    input wire [31:0] digest_word3,
    input wire [31:0] digest_word4
);

    // messages ended at the input whose digest has not been popped yet
    logic [3:0] open_reg, open_next;
    logic       msg_in, msg_out;

    assign msg_in  = push && !full && last;
    assign msg_out = pop && !empty;

    always_comb
    begin
        open_next = open_reg;
        if (msg_in && !msg_out)
            open_next = open_reg + 4'd1;
        else if (msg_out && !msg_in)
            open_next = open_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else
            open_reg <= open_next;
    end

    // after reset is seen low the result side must read empty
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (open_reg != 4'd0))
        else $error("digest shown without an ended message");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting digest withdrawn");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(digest_word0) && $stable(digest_word1)
                              && $stable(digest_word2) && $stable(digest_word3)
                              && $stable(digest_word4)))
        else $error("waiting digest changed");

endmodule

bind sha1_hash_engine_core sha1e_checker u_sha1e_checker (.*);

`default_nettype wire

// ===== verif/tb_sha1_hash_engine_core.sv =====
// Self-checking testbench for sha1_hash_engine_core: byte stream in, SHA-1 digest out.
// Depends on sha1e_pkg (chain constants, round constants, pad byte) and the engine RTL.
`timescale 1ns / 1ps

module tb_sha1_hash_engine_core;
    import sha1e_pkg::*;

    // Port-side signals
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;

    sha1_hash_engine_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .digest_word0 (digest_word0),
        .digest_word1 (digest_word1),
        .digest_word2 (digest_word2),
        .digest_word3 (digest_word3),
        .digest_word4 (digest_word4)
    );

    // One input word as the sender sees it. hold makes the sender wait until
    // every outstanding digest has been popped before presenting this word.
    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       fin;
        logic       hold;
    } byte_word_t;

    typedef struct packed {
        logic [CHAIN_WORDS-1:0][WORD_W-1:0] h;
    } digest_t;

    byte_word_t pending_words[$];
    digest_t    expected_digests[$];

    // Own copy of the hash state, advanced on every accepted word
    logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_m;
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] blk_m;
    logic [TOTAL_W-1:0]                 bytes_m;

    int  mismatches;
    int  counted_words;
    int  msg_count;
    bit  took_word;
    bit  took_digest;
    bit  send_burst;
    bit  pop_burst;
    int  send_wait;
    int  pop_wait;
    byte_word_t nxt_word;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------

    // 80-round compression of blk_m into chain_m
    task automatic compress_block_model();
        logic [WORD_W-1:0] sched [0:79];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, t, x;
        int r;
        for (r = 0; r < 16; r++)
            sched[r] = blk_m[r];
        for (r = 16; r < 80; r++)
        begin
            x = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
            sched[r] = {x[30:0], x[31]};
        end
        a = chain_m[0];
        b = chain_m[1];
        c = chain_m[2];
        d = chain_m[3];
        e = chain_m[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_P1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_P2;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_m[0] = chain_m[0] + a;
        chain_m[1] = chain_m[1] + b;
        chain_m[2] = chain_m[2] + c;
        chain_m[3] = chain_m[3] + d;
        chain_m[4] = chain_m[4] + e;
    endtask

    // Big-endian byte store; lanes below the new byte are cleared
    task automatic store_byte(input logic [5:0] pos, input logic [7:0] b);
        logic [WORD_W-1:0] w;
        w = blk_m[pos[5:2]];
        case (pos[1:0])
            2'd0: w = {b, 24'h0};
            2'd1: w = {w[31:24], b, 16'h0};
            2'd2: w = {w[31:16], b, 8'h0};
            default: w = {w[31:8], b};
        endcase
        blk_m[pos[5:2]] = w;
    endtask

    // Advance the model by one accepted word; a closing word queues a digest
    task automatic absorb_word(input logic [7:0] db, input logic hb, input logic fin);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        digest_t     dg;
        int          i;
        if (hb)
        begin
            pos = bytes_m[5:0];
            store_byte(pos, db);
            bytes_m = bytes_m + 1'b1;
            if (pos == 6'd63)
                compress_block_model();
        end
        if (fin)
        begin
            pos     = bytes_m[5:0];
            bit_len = {bytes_m, 3'b000};
            store_byte(pos, PAD_BYTE);
            for (i = int'(pos[5:2]) + 1; i < 16; i++)
                blk_m[i] = '0;
            // no room for the length: extra block
            if (pos >= 6'd56)
            begin
                compress_block_model();
                for (i = 0; i < 14; i++)
                    blk_m[i] = '0;
            end
            blk_m[14] = bit_len[63:32];
            blk_m[15] = bit_len[31:0];
            compress_block_model();
            dg.h = chain_m;
            expected_digests.insert(expected_digests.size(), dg);
            chain_m = INIT_CHAIN;
            bytes_m = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_word(input logic [7:0] d, input logic hb, input logic fin,
                             input logic hold);
        byte_word_t w;
        w.data = d;
        w.has  = hb;
        w.fin  = fin;
        w.hold = hold;
        pending_words.insert(pending_words.size(), w);
        if (hb || fin)
            counted_words++;
    endtask

    // One message of len bytes; either the last byte closes it or a bare end does.
    // Ignored words (no byte, no last) are sprinkled in as noise.
    task automatic add_message(input int len, input bit bare_end, input bit hold);
        int  i;
        bit  first;
        bit  bare;
        first = hold;
        bare  = bare_end || (len == 0);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                push_word(8'($urandom), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            push_word(8'($urandom), 1'b1, (i == len - 1) && !bare, first);
            first = 1'b0;
        end
        if (bare)
            push_word(8'($urandom), 1'b0, 1'b1, first);
        msg_count++;
    endtask

    function automatic int pick_length();
        int sel;
        int boundary [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 12);
        else if (sel < 6)
            return boundary[$urandom_range(0, 9)];
        else
            return $urandom_range(0, 150);
    endfunction

    // ------------------------------------------------------------------
    // Reset, stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        data_byte   = 8'h00;
        has_byte    = 1'b0;
        last        = 1'b0;
        mismatches  = 0;
        took_word   = 1'b0;
        took_digest = 1'b0;
        send_burst  = 1'b0;
        pop_burst   = 1'b0;
        send_wait   = 0;
        pop_wait    = 0;
        chain_m     = INIT_CHAIN;
        blk_m       = '0;
        bytes_m     = '0;

        // Directed: empty messages, "abc", byte extremes, noise word, bare end
        push_word(8'hA5, 1'b0, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1, 1'b0);
        push_word(8'h61, 1'b1, 1'b0, 1'b0);
        push_word(8'h62, 1'b1, 1'b0, 1'b0);
        push_word(8'h63, 1'b1, 1'b1, 1'b0);
        push_word(8'hFF, 1'b1, 1'b0, 1'b0);
        push_word(8'h5A, 1'b0, 1'b0, 1'b0);
        push_word(8'h00, 1'b1, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1, 1'b0);
        push_word(8'h80, 1'b1, 1'b1, 1'b0);

        // Random messages; sender drains the result side now and then
        msg_count = 0;
        while (counted_words < 1750 || msg_count < 48)
            add_message(pick_length(), 1'($urandom_range(0, 1)),
                        (msg_count == 0) || (msg_count % 17 == 0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || push)
            @(posedge clk);
        while (expected_digests.size() != 0)
            @(posedge clk);
        // two compressions is the longest tail
        repeat (400) @(posedge clk);

        if (mismatches == 0 && expected_digests.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sampling at the rising edge: prediction and checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : sample_edge
        digest_t exp_dg;
        logic [CHAIN_WORDS-1:0][WORD_W-1:0] got;
        int i;
        if (rst_n)
        begin
            if (push && !full)
            begin
                absorb_word(data_byte, has_byte, last);
                took_word = 1'b1;
            end
            if (pop && !empty)
            begin
                took_digest = 1'b1;
                got = {digest_word4, digest_word3, digest_word2, digest_word1,
                       digest_word0};
                if (expected_digests.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: digest popped with none expected: %h", $realtime,
                                 got);
                end
                else
                begin
                    exp_dg = expected_digests.pop_front();
                    for (i = 0; i < CHAIN_WORDS; i++)
                        if (got[i] !== exp_dg.h[i])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("%0t: digest_word%0d expected %h got %h",
                                         $realtime, i, exp_dg.h[i], got[i]);
                        end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: presents pending words at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && !(push && !took_word))
        begin
            if (took_word)
            begin
                took_word = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, 13);
            end
            if (send_wait > 0)
            begin
                send_wait--;
                push <= 1'b0;
            end
            else if (pending_words.size() == 0)
                push <= 1'b0;
            else if (pending_words[0].hold && expected_digests.size() != 0)
                push <= 1'b0;
            else
            begin
                nxt_word = pending_words.pop_front();
                push      <= 1'b1;
                data_byte <= nxt_word.data;
                has_byte  <= nxt_word.has;
                last      <= nxt_word.fin;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random pop stalls, drawn once per digest
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_digest)
            begin
                took_digest = 1'b0;
                if ($urandom_range(0, 7) == 0)
                    pop_burst = !pop_burst;
                pop_wait = pop_burst ? 0 : $urandom_range(0, 13);
            end
            if (pop_wait > 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

endmodule
